// ===== rtl/mi3_pkg.sv =====
// Shared constants for the 3x3 matrix inverse pipeline.
// Used by matrix3_inverse_top and its port checker; no other dependencies.
package mi3_pkg;

    localparam int unsigned ELEM_WIDTH_DEF = 32;
    localparam int unsigned FRAC_BITS_DEF  = 16;

    // Element indexes: xx0 xy1 xz2 yx3 yy4 yz5 zx6 zy7 zz8
    // Cofactor k = e[a]*e[b] - e[c]*e[d], row entries {a, b, c, d}
    localparam logic [3:0] COF_IDX [9][4] = '{
        '{4'd4, 4'd8, 4'd5, 4'd7},
        '{4'd2, 4'd7, 4'd8, 4'd1},
        '{4'd1, 4'd5, 4'd2, 4'd4},
        '{4'd5, 4'd6, 4'd8, 4'd3},
        '{4'd0, 4'd8, 4'd2, 4'd6},
        '{4'd2, 4'd3, 4'd5, 4'd0},
        '{4'd3, 4'd7, 4'd4, 4'd6},
        '{4'd1, 4'd6, 4'd0, 4'd7},
        '{4'd0, 4'd4, 4'd1, 4'd3}
    };

endpackage

// ===== rtl/matrix3_inverse_top.sv =====
// 3x3 matrix inverse by the adjugate, Q(ELEM_WIDTH-FRAC_BITS).FRAC_BITS fixed point.
// Depends on mi3_pkg for parameter defaults and the cofactor index table.
// Throughput: one item per cycle while not stalled; the reciprocal is a restoring
//   divider unrolled into one pipeline stage per quotient bit (2*FRAC_BITS+1 stages).
// A stalled output freezes the whole pipeline; bubbles pass through otherwise.
// Reset (synchronous, active low) clears all valid bits; data registers are not reset.
module matrix3_inverse_top #(
    parameter int unsigned ELEM_WIDTH = mi3_pkg::ELEM_WIDTH_DEF,
    parameter int unsigned FRAC_BITS  = mi3_pkg::FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic signed [ELEM_WIDTH-1:0] i_in_xx,
    input  logic signed [ELEM_WIDTH-1:0] i_in_xy,
    input  logic signed [ELEM_WIDTH-1:0] i_in_xz,
    input  logic signed [ELEM_WIDTH-1:0] i_in_yx,
    input  logic signed [ELEM_WIDTH-1:0] i_in_yy,
    input  logic signed [ELEM_WIDTH-1:0] i_in_yz,
    input  logic signed [ELEM_WIDTH-1:0] i_in_zx,
    input  logic signed [ELEM_WIDTH-1:0] i_in_zy,
    input  logic signed [ELEM_WIDTH-1:0] i_in_zz,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic signed [ELEM_WIDTH-1:0] o_inv_xx,
    output logic signed [ELEM_WIDTH-1:0] o_inv_xy,
    output logic signed [ELEM_WIDTH-1:0] o_inv_xz,
    output logic signed [ELEM_WIDTH-1:0] o_inv_yx,
    output logic signed [ELEM_WIDTH-1:0] o_inv_yy,
    output logic signed [ELEM_WIDTH-1:0] o_inv_yz,
    output logic signed [ELEM_WIDTH-1:0] o_inv_zx,
    output logic signed [ELEM_WIDTH-1:0] o_inv_zy,
    output logic signed [ELEM_WIDTH-1:0] o_inv_zz,
    output logic signed [ELEM_WIDTH-1:0] o_determinant,
    output logic                         o_singular
);

    localparam int EW   = ELEM_WIDTH;
    localparam int SH   = 2 * FRAC_BITS;      // rescale shift
    localparam int QW   = 2 * FRAC_BITS + 1;  // quotient bits, one divider stage each
    localparam int PW   = 2 * EW;             // element product
    localparam int CW   = 2 * EW + 1;         // cofactor
    localparam int HW   = 2 * EW + 1;         // split partial product
    localparam int DW   = 3 * EW + 3;         // wide accumulate
    localparam int XW   = QW + EW;            // quotient compare width

    localparam logic signed [DW-1:0] PMAX_W = {{(DW-EW+1){1'b0}}, {(EW-1){1'b1}}};
    localparam logic signed [DW-1:0] NMIN_W = ~PMAX_W;
    localparam logic signed [EW-1:0] PMAX_E = {1'b0, {(EW-1){1'b1}}};
    localparam logic signed [EW-1:0] NMIN_E = {1'b1, {(EW-1){1'b0}}};
    localparam logic [XW-1:0]        PMAX_X = {{(XW-EW+1){1'b0}}, {(EW-1){1'b1}}};
    localparam logic [XW-1:0]        PMIN_X = {{(XW-EW){1'b0}}, 1'b1, {(EW-1){1'b0}}};

    // Shift right by SH rounding toward zero, then saturate to the element range
    function automatic logic signed [EW-1:0] f_shr_sat(input logic signed [DW-1:0] a);
        logic signed [DW-1:0] s;
        logic                 rnd;
        s   = a >>> SH;
        rnd = a[DW-1] && (a[SH-1:0] != '0);
        s   = s + $signed({{(DW-1){1'b0}}, rnd});
        if (s > PMAX_W) begin
            return PMAX_E;
        end else if (s < NMIN_W) begin
            return NMIN_E;
        end else begin
            return s[EW-1:0];
        end
    endfunction

    logic signed [EW-1:0] e [9];
    logic                 en;

    // Stage registers
    logic                 r_s1_v;
    logic signed [PW-1:0] r_s1_p [18];
    logic signed [EW-1:0] r_s1_e [3];
    logic                 r_s2_v;
    logic signed [CW-1:0] r_s2_c [9];
    logic signed [EW-1:0] r_s2_e [3];
    logic                 r_s3_v;
    logic signed [HW-1:0] r_s3_lo [3];
    logic signed [HW-1:0] r_s3_hi [3];
    logic signed [CW-1:0] r_s3_c [9];
    logic                 r_s4_v;
    logic signed [DW-1:0] r_s4_dex;
    logic signed [CW-1:0] r_s4_c [9];

    // Divider line; entry 0 is the determinant stage
    logic                 r_dv [QW+1];
    logic [EW-1:0]        r_dm [QW+1];
    logic [EW-1:0]        r_dr [QW+1];
    logic [QW-1:0]        r_dq [QW+1];
    logic                 r_dn [QW+1];
    logic                 r_ds [QW+1];
    logic signed [EW-1:0] r_dd [QW+1];
    logic signed [CW-1:0] r_dc [QW+1][9];
    logic [EW-1:0]        n_dr [QW+1];
    logic [QW-1:0]        n_dq [QW+1];

    logic                 r_s6_v;
    logic signed [EW-1:0] r_s6_rec;
    logic                 r_s6_s;
    logic signed [EW-1:0] r_s6_d;
    logic signed [CW-1:0] r_s6_c [9];
    logic                 r_s7_v;
    logic signed [HW-1:0] r_s7_lo [9];
    logic signed [HW-1:0] r_s7_hi [9];
    logic                 r_s7_s;
    logic signed [EW-1:0] r_s7_d;
    logic                 r_s8_v;
    logic signed [DW-1:0] r_s8_p [9];
    logic                 r_s8_s;
    logic signed [EW-1:0] r_s8_d;
    logic                 r_ov;
    logic signed [EW-1:0] r_inv [9];
    logic signed [EW-1:0] r_det;
    logic                 r_sing;

    logic signed [EW-1:0] n_det;
    logic [XW-1:0]        n_qx;
    logic signed [EW-1:0] n_rec;

    assign e[0] = i_in_xx;
    assign e[1] = i_in_xy;
    assign e[2] = i_in_xz;
    assign e[3] = i_in_yx;
    assign e[4] = i_in_yy;
    assign e[5] = i_in_yz;
    assign e[6] = i_in_zx;
    assign e[7] = i_in_zy;
    assign e[8] = i_in_zz;

    // Whole pipeline holds only when a result is waiting and stalled
    assign en      = !(r_ov && i_stall);
    assign o_stall = !en;

    // Divider steps: bring down one numerator bit (only the top one is set)
    always_comb begin
        logic [EW:0] trial;
        logic [EW:0] diff;
        n_dr[0] = '0;
        n_dq[0] = '0;
        trial   = '0;
        diff    = '0;
        for (int k = 1; k <= QW; k++) begin
            trial = {r_dr[k-1], (k == 1)};
            diff  = trial - {1'b0, r_dm[k-1]};
            if (trial >= {1'b0, r_dm[k-1]}) begin
                n_dr[k] = diff[EW-1:0];
                n_dq[k] = {r_dq[k-1][QW-2:0], 1'b1};
            end else begin
                n_dr[k] = trial[EW-1:0];
                n_dq[k] = {r_dq[k-1][QW-2:0], 1'b0};
            end
        end
    end

    // Determinant rescale and reciprocal saturation
    always_comb begin
        n_det = f_shr_sat(r_s4_dex);
        n_qx  = XW'(r_dq[QW]);
        if (!r_dn[QW]) begin
            n_rec = (n_qx > PMAX_X) ? PMAX_E : $signed(n_qx[EW-1:0]);
        end else begin
            n_rec = (n_qx > PMIN_X) ? NMIN_E : $signed(EW'(-n_qx));
        end
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_s4_v <= 1'b0;
            for (int k = 0; k <= QW; k++) begin
                r_dv[k] <= 1'b0;
            end
            r_s6_v <= 1'b0;
            r_s7_v <= 1'b0;
            r_s8_v <= 1'b0;
            r_ov   <= 1'b0;
        end else if (en) begin
            r_s1_v  <= i_valid;
            r_s2_v  <= r_s1_v;
            r_s3_v  <= r_s2_v;
            r_s4_v  <= r_s3_v;
            r_dv[0] <= r_s4_v;
            for (int k = 1; k <= QW; k++) begin
                r_dv[k] <= r_dv[k-1];
            end
            r_s6_v <= r_dv[QW];
            r_s7_v <= r_s6_v;
            r_s8_v <= r_s7_v;
            r_ov   <= r_s8_v;
        end
    end

    // Data path
    always_ff @(posedge i_clk) begin
        if (en) begin
            // element products
            for (int k = 0; k < 9; k++) begin
                r_s1_p[2*k]   <= e[mi3_pkg::COF_IDX[k][0]] * e[mi3_pkg::COF_IDX[k][1]];
                r_s1_p[2*k+1] <= e[mi3_pkg::COF_IDX[k][2]] * e[mi3_pkg::COF_IDX[k][3]];
            end
            r_s1_e[0] <= e[6];
            r_s1_e[1] <= e[7];
            r_s1_e[2] <= e[8];

            // cofactors
            for (int k = 0; k < 9; k++) begin
                r_s2_c[k] <= CW'(r_s1_p[2*k]) - CW'(r_s1_p[2*k+1]);
            end
            r_s2_e <= r_s1_e;

            // determinant partial products: c2*zx, c5*zy, c8*zz
            for (int j = 0; j < 3; j++) begin
                r_s3_lo[j] <= $signed({1'b0, r_s2_c[2+3*j][EW-1:0]}) * r_s2_e[j];
                r_s3_hi[j] <= $signed(r_s2_c[2+3*j][CW-1:EW]) * r_s2_e[j];
            end
            r_s3_c <= r_s2_c;

            // exact determinant
            r_s4_dex <= ((DW'(r_s3_hi[0]) <<< EW) + DW'(r_s3_lo[0]))
                      + ((DW'(r_s3_hi[1]) <<< EW) + DW'(r_s3_lo[1]))
                      + ((DW'(r_s3_hi[2]) <<< EW) + DW'(r_s3_lo[2]));
            r_s4_c   <= r_s3_c;

            // rescaled determinant, divisor magnitude
            r_dd[0] <= n_det;
            r_ds[0] <= (n_det == '0);
            r_dn[0] <= n_det[EW-1];
            r_dm[0] <= n_det[EW-1] ? EW'(-n_det) : n_det;
            r_dr[0] <= n_dr[0];
            r_dq[0] <= n_dq[0];
            r_dc[0] <= r_s4_c;

            // reciprocal, one quotient bit per stage
            for (int k = 1; k <= QW; k++) begin
                r_dd[k] <= r_dd[k-1];
                r_ds[k] <= r_ds[k-1];
                r_dn[k] <= r_dn[k-1];
                r_dm[k] <= r_dm[k-1];
                r_dr[k] <= n_dr[k];
                r_dq[k] <= n_dq[k];
                r_dc[k] <= r_dc[k-1];
            end

            r_s6_rec <= n_rec;
            r_s6_s   <= r_ds[QW];
            r_s6_d   <= r_dd[QW];
            r_s6_c   <= r_dc[QW];

            // cofactor times reciprocal, split in halves
            for (int k = 0; k < 9; k++) begin
                r_s7_lo[k] <= $signed({1'b0, r_s6_c[k][EW-1:0]}) * r_s6_rec;
                r_s7_hi[k] <= $signed(r_s6_c[k][CW-1:EW]) * r_s6_rec;
            end
            r_s7_s <= r_s6_s;
            r_s7_d <= r_s6_d;

            for (int k = 0; k < 9; k++) begin
                r_s8_p[k] <= (DW'(r_s7_hi[k]) <<< EW) + DW'(r_s7_lo[k]);
            end
            r_s8_s <= r_s7_s;
            r_s8_d <= r_s7_d;

            // output register; singular forces zeros
            for (int k = 0; k < 9; k++) begin
                r_inv[k] <= r_s8_s ? '0 : f_shr_sat(r_s8_p[k]);
            end
            r_det  <= r_s8_d;
            r_sing <= r_s8_s;
        end
    end

    assign o_valid       = r_ov;
    assign o_inv_xx      = r_inv[0];
    assign o_inv_xy      = r_inv[1];
    assign o_inv_xz      = r_inv[2];
    assign o_inv_yx      = r_inv[3];
    assign o_inv_yy      = r_inv[4];
    assign o_inv_yz      = r_inv[5];
    assign o_inv_zx      = r_inv[6];
    assign o_inv_zy      = r_inv[7];
    assign o_inv_zz      = r_inv[8];
    assign o_determinant = r_det;
    assign o_singular    = r_sing;

endmodule

// ===== rtl/mi3_checker.sv =====
// Port-level checker for matrix3_inverse_top, attached by bind below.
// Depends on mi3_pkg for the default element width.
module mi3_checker #(
    parameter int unsigned ELEM_WIDTH = mi3_pkg::ELEM_WIDTH_DEF
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_valid,
    input logic                  i_stall,
    input logic                  o_stall,
    input logic [ELEM_WIDTH-1:0] o_inv_xx,
    input logic [ELEM_WIDTH-1:0] o_inv_yy,
    input logic [ELEM_WIDTH-1:0] o_inv_zz,
    input logic [ELEM_WIDTH-1:0] o_determinant,
    input logic                  o_singular
);

    // no result right after reset
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("valid result after reset");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_determinant) && $stable(o_singular))
        else $error("stalled result changed");

    // singular flag matches the determinant
    a_sing_det: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_singular == (o_determinant == '0)))
        else $error("singular flag disagrees with determinant");

    // singular result has a zero inverse
    a_sing_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_singular |-> o_inv_xx == '0 && o_inv_yy == '0 && o_inv_zz == '0)
        else $error("singular item has nonzero inverse");

    // input is held back only by a waiting result
    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without a stalled result");

endmodule

bind matrix3_inverse_top mi3_checker #(.ELEM_WIDTH(ELEM_WIDTH)) u_mi3_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_stall       (o_stall),
    .o_inv_xx      (o_inv_xx),
    .o_inv_yy      (o_inv_yy),
    .o_inv_zz      (o_inv_zz),
    .o_determinant (o_determinant),
    .o_singular    (o_singular)
);
